[hdl/gbq_pkg.sv]
// Shared types, constants and helper functions of the gamepad button qualifier.
// Used by the configuration registers, the key unit and the top level.
// Depends on nothing else.
package gbq_pkg;

  // Default sizes of the per-pad state.
  localparam int unsigned PAD_COUNT = 4;
  localparam int unsigned KEY_COUNT = 18;

  // Field widths.
  localparam int unsigned PAD_W   = 2;
  localparam int unsigned BTN_W   = 16;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned DZ_W    = 15;
  localparam int unsigned DIR_W   = 4;
  localparam int unsigned MASK_W  = 18;
  localparam int unsigned CNT_W   = 8;
  // Stored key word: buttons in the low bits, right-stick flags above them.
  localparam int unsigned WORD_W  = BTN_W + DIR_W;
  localparam int unsigned WIDX_W  = $clog2(WORD_W);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] REPEAT_START_RST    = 8'd40;
  localparam logic [CNT_W-1:0] REPEAT_INTERVAL_RST = 8'd10;
  localparam logic [DZ_W-1:0]  LEFT_DZ_RST         = 15'd7849;
  localparam logic [DZ_W-1:0]  RIGHT_DZ_RST        = 15'd8689;

  // D-pad bit positions in the button word.
  localparam int unsigned DPAD_UP_BIT    = 0;
  localparam int unsigned DPAD_DOWN_BIT  = 1;
  localparam int unsigned DPAD_LEFT_BIT  = 2;
  localparam int unsigned DPAD_RIGHT_BIT = 3;

  // Right-stick flag positions.
  localparam int unsigned RDIR_RIGHT_BIT = 0;
  localparam int unsigned RDIR_LEFT_BIT  = 1;
  localparam int unsigned RDIR_UP_BIT    = 2;
  localparam int unsigned RDIR_DOWN_BIT  = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAYBACK_MODE   = 3'd0,
    CFG_REPEAT_START    = 3'd1,
    CFG_REPEAT_INTERVAL = 3'd2,
    CFG_LEFT_DEADZONE   = 3'd3,
    CFG_RIGHT_DEADZONE  = 3'd4
  } cfg_reg_e;

  // One poll of one pad.
  typedef struct packed {
    logic [PAD_W-1:0]         pad_index;
    logic                     connected;
    logic [BTN_W-1:0]         button_bits;
    logic signed [AXIS_W-1:0] left_x;
    logic signed [AXIS_W-1:0] left_y;
    logic signed [AXIS_W-1:0] right_x;
    logic signed [AXIS_W-1:0] right_y;
  } poll_t;

  // One result item.
  typedef struct packed {
    logic [PAD_W-1:0]  pad_number;
    logic              pad_present;
    logic [MASK_W-1:0] held_mask;
    logic [MASK_W-1:0] pressed_mask;
    logic [MASK_W-1:0] released_mask;
    logic [MASK_W-1:0] repeat_mask;
    logic [DIR_W-1:0]  right_dirs;
  } result_t;

  // One configuration write.
  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_t;

  // Current register settings, handed to the datapath.
  typedef struct packed {
    logic             playback_mode;
    logic [CNT_W-1:0] repeat_start;
    logic [CNT_W-1:0] repeat_interval;
    logic [DZ_W-1:0]  left_deadzone;
    logic [DZ_W-1:0]  right_deadzone;
  } cfg_regs_t;

  // Where a virtual key takes its bit from in the stored key word.
  typedef struct packed {
    logic              en;
    logic [WIDX_W-1:0] idx;
  } key_src_t;

  // Virtual key order: left right up down, rleft rright rup rdown, X A B Y,
  // shoulders, thumbs, start, back. Keys past the list have no source.
  function automatic key_src_t key_src(input int k);
    key_src_t s;
    s.en = 1'b1;
    unique case (k)
      0:       s.idx = 5'd2;
      1:       s.idx = 5'd3;
      2:       s.idx = 5'd0;
      3:       s.idx = 5'd1;
      4:       s.idx = 5'd17;
      5:       s.idx = 5'd16;
      6:       s.idx = 5'd18;
      7:       s.idx = 5'd19;
      8:       s.idx = 5'd14;
      9:       s.idx = 5'd12;
      10:      s.idx = 5'd13;
      11:      s.idx = 5'd15;
      12:      s.idx = 5'd8;
      13:      s.idx = 5'd9;
      14:      s.idx = 5'd6;
      15:      s.idx = 5'd7;
      16:      s.idx = 5'd4;
      17:      s.idx = 5'd5;
      default: begin
        s.en  = 1'b0;
        s.idx = 5'd0;
      end
    endcase
    return s;
  endfunction

  // Deadzone test of one axis: bit 0 is past the positive edge, bit 1 past
  // the negative edge.
  function automatic logic [1:0] dz_flags(input logic signed [AXIS_W-1:0] x,
                                          input logic [DZ_W-1:0] dz);
    logic signed [AXIS_W:0] xs;
    logic signed [AXIS_W:0] pos;
    logic signed [AXIS_W:0] neg;
    xs  = {x[AXIS_W-1], x};
    pos = $signed({2'b00, dz});
    neg = -pos;
    return {xs < neg, xs > pos};
  endfunction

endpackage

[hdl/gbq_stream_if.sv]
// Valid/ready channel used for polls, results and configuration writes.
// The payload type is a parameter; the types come from gbq_pkg.
// Depends on nothing else.
interface gbq_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/gbq_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// A read at the address being written returns the old contents.
// Depends on nothing else.
module gbq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/gbq_cfg_regs.sv]
// Configuration register file of the gamepad button qualifier.
// Takes writes from the configuration channel; uses gbq_pkg and gbq_stream_if.
module gbq_cfg_regs
  import gbq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  gbq_stream_if.sink       cfg_i,
  output cfg_regs_t        regs_o
);

  cfg_regs_t regs_q;
  cfg_regs_t regs_d;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Decode one write transfer; unknown indexes are dropped.
  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        CFG_PLAYBACK_MODE:   regs_d.playback_mode   = cfg_i.data.wdata[0];
        CFG_REPEAT_START:    regs_d.repeat_start    = cfg_i.data.wdata[CNT_W-1:0];
        CFG_REPEAT_INTERVAL: regs_d.repeat_interval = cfg_i.data.wdata[CNT_W-1:0];
        CFG_LEFT_DEADZONE:   regs_d.left_deadzone   = cfg_i.data.wdata[DZ_W-1:0];
        CFG_RIGHT_DEADZONE:  regs_d.right_deadzone  = cfg_i.data.wdata[DZ_W-1:0];
        default:             regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.playback_mode   <= 1'b0;
      regs_q.repeat_start    <= REPEAT_START_RST;
      regs_q.repeat_interval <= REPEAT_INTERVAL_RST;
      regs_q.left_deadzone   <= LEFT_DZ_RST;
      regs_q.right_deadzone  <= RIGHT_DZ_RST;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

[hdl/gbq_key_unit.sv]
// Per-key edge detection and auto-repeat counter update for one pad.
// Purely combinational; sits between the state memory read and write-back.
// Uses gbq_pkg.
module gbq_key_unit
  import gbq_pkg::*;
#(
  parameter int unsigned KeyCount = KEY_COUNT
) (
  input  logic [WORD_W-1:0]              now_i,
  input  logic [WORD_W-1:0]              old_i,
  input  logic [KeyCount-1:0][CNT_W-1:0] cnt_i,
  input  logic                           active_i,
  input  logic [CNT_W-1:0]               repeat_start_i,
  input  logic [CNT_W-1:0]               repeat_interval_i,
  output logic [KeyCount-1:0][CNT_W-1:0] cnt_o,
  output logic [KeyCount-1:0]            held_o,
  output logic [KeyCount-1:0]            pressed_o,
  output logic [KeyCount-1:0]            released_o,
  output logic [KeyCount-1:0]            repeat_o
);

  for (genvar k = 0; k < KeyCount; k++) begin : g_key
    localparam key_src_t Src = key_src(k);

    logic             now_b;
    logic             old_b;
    logic             held;
    logic             pressed;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_new;
    logic [CNT_W:0]   cnt_plus;

    // Select the key's source bit in the current and previous words.
    assign now_b   = Src.en & now_i[Src.idx];
    assign old_b   = Src.en & old_i[Src.idx];
    assign held    = active_i & now_b;
    assign pressed = active_i & now_b & ~old_b;

    // Count while held, restart at one otherwise, fold back by the interval.
    assign cnt_inc = held ? cnt_i[k] + CNT_W'(1) : CNT_W'(1);
    assign cnt_new = (cnt_inc >= repeat_start_i) ? cnt_inc - repeat_interval_i : cnt_inc;

    // Repeat fires at one below the start threshold.
    assign cnt_plus = {1'b0, cnt_new} + (CNT_W+1)'(1);

    assign cnt_o[k]      = cnt_new;
    assign held_o[k]     = held;
    assign pressed_o[k]  = pressed;
    assign released_o[k] = active_i & old_b & ~now_b;
    assign repeat_o[k]   = active_i & (pressed | (cnt_plus >= {1'b0, repeat_start_i}));
  end

endmodule

[hdl/gamepad_button_qualifier_top.sv]
// Gamepad button qualifier: edge detection and auto-repeat for virtual keys.
// Channels: poll_i takes one poll of one pad per transfer, result_o gives one
// result per poll in the same order, cfg_i writes the configuration
// registers (always ready; write only while no poll is in flight).
// A poll accepted into the memory-read stage passes through the output register
// to result_o. Throughput: one poll per cycle unless the receiver stalls, also
// for back-to-back polls of the same pad. The per-pad state memories have a
// registered read; the write-back of the previous poll is forwarded around them.
// The left stick past its deadzone sets the d-pad buttons; the right stick
// gives four direction flags that also drive the right-stick virtual keys.
// Each pad keeps its last key word and one 8-bit repeat counter per key.
// Reset: all pads read as never pressed with zero counters, set through one
// valid bit per pad, so no clearing pass is needed; polls are taken at once.
// Registers return to playback off, start 40, interval 10, deadzones 7849
// and 8689. A stalled receiver holds the result register; one more poll is
// then taken into the memory-read stage before poll_i.ready drops.
// Depends on gbq_pkg, gbq_stream_if, gbq_ram, gbq_cfg_regs and gbq_key_unit.
module gamepad_button_qualifier_top
  import gbq_pkg::*;
#(
  parameter int unsigned PadCount = PAD_COUNT,
  parameter int unsigned KeyCount = KEY_COUNT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gbq_stream_if.sink    poll_i,
  gbq_stream_if.source  result_o,
  gbq_stream_if.sink    cfg_i
);

  localparam int unsigned AddrW = (PadCount > 1) ? $clog2(PadCount) : 1;
  localparam int unsigned CntVecW = KeyCount * CNT_W;

  cfg_regs_t cfg;

  // Handshake and pipeline control.
  logic in_fire;
  logic s1_fire;
  logic s2_ready;

  // Memory-read stage.
  logic              s1_valid_q;
  logic              s1_valid_d;
  logic [PAD_W-1:0]  s1_pad_q;
  logic              s1_conn_q;
  logic              s1_in_range_q;
  logic [AddrW-1:0]  s1_addr_q;
  logic [WORD_W-1:0] s1_word_q;

  // Accept-side decode.
  logic [AddrW+PAD_W-1:0] in_addr_ext;
  logic [AddrW-1:0]       in_addr;
  logic                   in_range;
  logic [BTN_W-1:0]       in_btn;
  logic [DIR_W-1:0]       in_rdirs;
  logic [1:0]             lx_flags;
  logic [1:0]             ly_flags;
  logic [1:0]             rx_flags;
  logic [1:0]             ry_flags;

  // State memories and forwarding.
  logic                               wr_en;
  logic [WORD_W-1:0]                  word_rdata;
  logic [CntVecW-1:0]                 cnt_rdata;
  logic [PadCount-1:0]                vld_q;
  logic                               fwd_vld_q;
  logic [AddrW-1:0]                   fwd_addr_q;
  logic [WORD_W-1:0]                  fwd_word_q;
  logic [CntVecW-1:0]                 fwd_cnt_q;
  logic                               fwd_hit;
  logic [WORD_W-1:0]                  old_word;
  logic [KeyCount-1:0][CNT_W-1:0]     old_cnt;
  logic [KeyCount-1:0][CNT_W-1:0]     new_cnt;

  // Key unit results.
  logic                active;
  logic [KeyCount-1:0] held;
  logic [KeyCount-1:0] pressed;
  logic [KeyCount-1:0] released;
  logic [KeyCount-1:0] repeats;

  // Output register.
  logic    res_valid_q;
  logic    res_valid_d;
  result_t res_q;
  result_t res_d;

  gbq_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (cfg)
  );

  // Ready chain: the output register frees a slot for the read stage.
  assign s2_ready     = !res_valid_q || result_o.ready;
  assign s1_fire      = s1_valid_q && s2_ready;
  assign poll_i.ready = !s1_valid_q || s2_ready;
  assign in_fire      = poll_i.valid && poll_i.ready;

  // Pad address and range check.
  assign in_addr_ext = {{AddrW{1'b0}}, poll_i.data.pad_index};
  assign in_addr     = in_addr_ext[AddrW-1:0];
  assign in_range    = 32'(poll_i.data.pad_index) < PadCount;

  // Deadzone tests; a disconnected pad stores nothing pressed.
  assign lx_flags = dz_flags(poll_i.data.left_x, cfg.left_deadzone);
  assign ly_flags = dz_flags(poll_i.data.left_y, cfg.left_deadzone);
  assign rx_flags = dz_flags(poll_i.data.right_x, cfg.right_deadzone);
  assign ry_flags = dz_flags(poll_i.data.right_y, cfg.right_deadzone);

  always_comb begin
    in_btn   = '0;
    in_rdirs = '0;
    if (poll_i.data.connected) begin
      in_btn                 = poll_i.data.button_bits;
      in_btn[DPAD_RIGHT_BIT] = in_btn[DPAD_RIGHT_BIT] | lx_flags[0];
      in_btn[DPAD_LEFT_BIT]  = in_btn[DPAD_LEFT_BIT]  | lx_flags[1];
      in_btn[DPAD_UP_BIT]    = in_btn[DPAD_UP_BIT]    | ly_flags[0];
      in_btn[DPAD_DOWN_BIT]  = in_btn[DPAD_DOWN_BIT]  | ly_flags[1];
      in_rdirs[RDIR_RIGHT_BIT] = rx_flags[0];
      in_rdirs[RDIR_LEFT_BIT]  = rx_flags[1];
      in_rdirs[RDIR_UP_BIT]    = ry_flags[0];
      in_rdirs[RDIR_DOWN_BIT]  = ry_flags[1];
    end
  end

  // Read stage control.
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Read stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pad_q      <= poll_i.data.pad_index;
      s1_conn_q     <= poll_i.data.connected;
      s1_in_range_q <= in_range;
      s1_addr_q     <= in_addr;
      s1_word_q     <= {in_rdirs, in_btn};
    end
  end

  // Per-pad state: previous key word and repeat counters.
  assign wr_en = s1_fire && s1_in_range_q;

  gbq_ram #(
    .Width (WORD_W),
    .Depth (PadCount)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_word_q),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (word_rdata)
  );

  gbq_ram #(
    .Width (CntVecW),
    .Depth (PadCount)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (new_cnt),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (cnt_rdata)
  );

  // Valid bits: a pad never written reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[s1_addr_q] <= 1'b1;
    end
  end

  // Last write-back, forwarded to a read of the same pad that it overtook.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (wr_en) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_addr_q;
      fwd_word_q <= s1_word_q;
      fwd_cnt_q  <= new_cnt;
    end
  end

  assign fwd_hit = fwd_vld_q && (fwd_addr_q == s1_addr_q);

  always_comb begin
    old_word = '0;
    old_cnt  = '0;
    if (fwd_hit) begin
      old_word = fwd_word_q;
      old_cnt  = fwd_cnt_q;
    end else if (s1_in_range_q && vld_q[s1_addr_q]) begin
      old_word = word_rdata;
      old_cnt  = cnt_rdata;
    end
  end

  // Key edges and auto-repeat.
  assign active = s1_in_range_q && s1_conn_q && !cfg.playback_mode;

  gbq_key_unit #(
    .KeyCount (KeyCount)
  ) u_key_unit (
    .now_i             (s1_word_q),
    .old_i             (old_word),
    .cnt_i             (old_cnt),
    .active_i          (active),
    .repeat_start_i    (cfg.repeat_start),
    .repeat_interval_i (cfg.repeat_interval),
    .cnt_o             (new_cnt),
    .held_o            (held),
    .pressed_o         (pressed),
    .released_o        (released),
    .repeat_o          (repeats)
  );

  // Result assembly; keys past the configured count read as zero.
  always_comb begin
    res_d               = '0;
    res_d.pad_number    = s1_pad_q;
    res_d.pad_present   = s1_conn_q;
    res_d.right_dirs    = active ? s1_word_q[WORD_W-1:BTN_W] : '0;
    for (int k = 0; k < MASK_W; k++) begin
      if (k < KeyCount) begin
        res_d.held_mask[k]     = held[k];
        res_d.pressed_mask[k]  = pressed[k];
        res_d.released_mask[k] = released[k];
        res_d.repeat_mask[k]   = repeats[k];
      end
    end
  end

  // Output register.
  assign res_valid_d = s1_fire || (res_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  // A poll is refused only when both stages are full and the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !poll_i.ready |-> (s1_valid_q && res_valid_q && !result_o.ready))
    else $error("poll refused while a stage was free");

  // A write-back becomes the forwarding source for its pad.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (fwd_vld_q && fwd_addr_q == $past(s1_addr_q) && vld_q[fwd_addr_q]))
    else $error("forwarding register lost a write-back");

  // A disconnected pad stores an empty key word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !s1_conn_q) |-> (s1_word_q == '0))
    else $error("disconnected pad stored key bits");

  // A key cannot be pressed and released in the same poll.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((res_q.pressed_mask & res_q.released_mask) == '0))
    else $error("key both pressed and released");

  // Every pressed key is also held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((res_q.pressed_mask & ~res_q.held_mask) == '0))
    else $error("pressed key not held");

endmodule
